// ===== rtl/ncdf_pkg.sv =====
// ============================================================================
// ncdf_pkg: shared constants and types for the normal CDF pipeline
// Fixed-point formats, polynomial coefficients, series divisor tables and
// the stage counts of each pipeline section.
// ============================================================================
package ncdf_pkg;

    localparam int IN_WIDTH_DEF  = 32;
    localparam int OUT_WIDTH_DEF = 32;

    // Internal widths.
    localparam int MAG_W = 32;   // |x| in unsigned Q5.27
    localparam int T_W   = 37;   // x*x/2 in Q.32, below the far-tail limit
    localparam int DEN_W = 35;   // 1 + gamma*|x| in Q.32
    localparam int REM_W = 35;   // divider remainder
    localparam int E_W   = 33;   // exp(-q) in Q.32, up to and including 1.0
    localparam int G_W   = 31;   // density in Q.32
    localparam int H_W   = 34;   // signed Horner accumulator in Q.30
    localparam int N_W   = 6;    // power-of-two exponent of the range reduction

    localparam logic [E_W-1:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [31:0]    ONE_Q31 = 32'h8000_0000;

    localparam logic [31:0] GAMMA_Q32 =
        32'(((64'd231641900 << 32) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] CO1_Q30 =
        32'(((64'd319381530 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] CO2_Q30 =
        32'(((64'd356563782 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] CO3_Q30 =
        32'(((64'd1781477937 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] CO4_Q30 =
        32'(((64'd1821255978 << 30) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] CO5_Q30 =
        32'(((64'd1330274429 << 30) + 64'd500000000) / 64'd1000000000);

    localparam logic [31:0] INV_ROOT_2PI_Q32 = 32'd1713444047;
    localparam logic [31:0] LN2_Q32          = 32'd2977044472;

    // Estimate of t / ln2 from the top bits of t; one correction step follows.
    localparam int          T_HI_LSB   = 26;
    localparam int          NEST_SHIFT = 24;
    localparam logic [18:0] N_RECIP    = 19'((64'd1 << 50) / 64'd2977044472);

    // Series stages run with divisors 13 down to 1. Each division by a
    // constant is an exact multiply by ceil(2^s/j) and a shift by s.
    localparam int SERIES_TERMS = 13;
    localparam logic [32:0] SER_MUL [SERIES_TERMS] = '{
        33'(((64'd1 << 36) + 64'd12) / 64'd13),
        33'(((64'd1 << 36) + 64'd11) / 64'd12),
        33'(((64'd1 << 36) + 64'd10) / 64'd11),
        33'(((64'd1 << 36) + 64'd9) / 64'd10),
        33'(((64'd1 << 36) + 64'd8) / 64'd9),
        33'(((64'd1 << 35) + 64'd7) / 64'd8),
        33'(((64'd1 << 35) + 64'd6) / 64'd7),
        33'(((64'd1 << 35) + 64'd5) / 64'd6),
        33'(((64'd1 << 35) + 64'd4) / 64'd5),
        33'(((64'd1 << 34) + 64'd3) / 64'd4),
        33'(((64'd1 << 34) + 64'd2) / 64'd3),
        33'(((64'd1 << 33) + 64'd1) / 64'd2),
        33'((64'd1 << 32) / 64'd1)
    };
    localparam int SER_SHIFT [SERIES_TERMS] = '{
        36, 36, 36, 36, 36, 35, 35, 35, 35, 34, 34, 33, 32
    };

    // Horner: start at c5, then after each multiply add -c4, c3, -c2, c1.
    localparam int HORN_STEPS = 5;
    localparam logic signed [H_W-1:0] HORN_INIT = $signed({2'b00, CO5_Q30});
    localparam logic signed [H_W-1:0] HORN_ADD [HORN_STEPS-1] = '{
        -$signed({2'b00, CO4_Q30}),
         $signed({2'b00, CO3_Q30}),
        -$signed({2'b00, CO2_Q30}),
         $signed({2'b00, CO1_Q30})
    };

    // Stage counts.
    localparam int FRONT_LAT  = 3;
    localparam int EXP_LAT    = 3 + 2 * SERIES_TERMS + 2;
    localparam int RECIP_LAT  = 32;
    localparam int HORNER_LAT = 2 * HORN_STEPS;
    localparam int GAUSS_DLY  = RECIP_LAT + HORNER_LAT - EXP_LAT;
    localparam int NEG_DLY    = RECIP_LAT + HORNER_LAT;
    localparam int PIPE_DEPTH = FRONT_LAT + RECIP_LAT + HORNER_LAT + 2;

    typedef struct packed {
        logic neg;
        logic far;
    } front_flags_t;

endpackage

// ===== rtl/ncdf_front.sv =====
// ============================================================================
// ncdf_front: argument conditioning
// Takes |x|, forms x*x/2 and the reciprocal denominator 1 + gamma*|x|.
// ============================================================================
module ncdf_front #(
    parameter int IN_WIDTH = ncdf_pkg::IN_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [IN_WIDTH-1:0]         x_in,
    output logic [ncdf_pkg::T_W-1:0]    t,
    output logic [ncdf_pkg::DEN_W-1:0]  den,
    output ncdf_pkg::front_flags_t      flags
);

    logic                          neg_c;
    logic [IN_WIDTH-1:0]           mag_c;
    logic [ncdf_pkg::MAG_W-1:0]    m_c;

    logic [ncdf_pkg::MAG_W-1:0]    m_reg;
    logic                          neg1_reg;
    logic [63:0]                   sq_reg;
    logic [63:0]                   mg_reg;
    logic                          neg2_reg;
    logic [ncdf_pkg::T_W-1:0]      t_reg;
    logic [ncdf_pkg::DEN_W-1:0]    den_reg;
    ncdf_pkg::front_flags_t        flags_reg;

    assign neg_c = x_in[IN_WIDTH-1];
    assign mag_c = neg_c ? (IN_WIDTH'(0) - x_in) : x_in;

    generate
        if (IN_WIDTH >= 32) begin : g_in_down
            assign m_c = ncdf_pkg::MAG_W'(mag_c >> (IN_WIDTH - 32));
        end else begin : g_in_up
            assign m_c = ncdf_pkg::MAG_W'(mag_c) << (32 - IN_WIDTH);
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg     <= m_c;
            neg1_reg  <= neg_c;
            sq_reg    <= 64'(m_reg) * 64'(m_reg);
            mg_reg    <= 64'(m_reg) * 64'(ncdf_pkg::GAMMA_Q32);
            neg2_reg  <= neg1_reg;
            // x*x/2 reaches 32.0 exactly when the square reaches 2^60.
            t_reg     <= sq_reg[59:23];
            flags_reg <= '{neg: neg2_reg, far: |sq_reg[63:60]};
            den_reg   <= ncdf_pkg::DEN_W'(ncdf_pkg::ONE_Q32) + mg_reg[61:27];
        end
    end

    assign t     = t_reg;
    assign den   = den_reg;
    assign flags = flags_reg;

endmodule

// ===== rtl/ncdf_exp.sv =====
// ============================================================================
// ncdf_exp: Gaussian density unit
// Range reduction t = n*ln2 + q, a 13-stage Horner series for exp(-q),
// then the 1/sqrt(2*pi) scale and the shift by n.
// ============================================================================
module ncdf_exp (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [ncdf_pkg::T_W-1:0]    t,
    input  logic                        far,
    output logic [ncdf_pkg::G_W-1:0]    gauss
);

    localparam int NT = ncdf_pkg::SERIES_TERMS;

    logic [29:0]                  nprod_c;
    logic [37:0]                  nl_c;
    logic [37:0]                  r_c;
    logic                         ge_c;

    logic [ncdf_pkg::T_W-1:0]     t1_reg;
    logic [ncdf_pkg::N_W-1:0]     n1_reg;
    logic                         far1_reg;
    logic [32:0]                  r2_reg;
    logic [ncdf_pkg::N_W-1:0]     n2_reg;
    logic                         far2_reg;
    logic [31:0]                  q3_reg;
    logic [ncdf_pkg::N_W-1:0]     n3_reg;
    logic                         far3_reg;

    logic [31:0]                  ser_q   [NT+1];
    logic [ncdf_pkg::E_W-1:0]     ser_e   [NT+1];
    logic [ncdf_pkg::N_W-1:0]     ser_n   [NT+1];
    logic                         ser_far [NT+1];

    logic [64:0]                  g1prod_c;
    logic [ncdf_pkg::G_W-1:0]     g1_reg;
    logic [ncdf_pkg::N_W-1:0]     nd_reg;
    logic                         fard_reg;
    logic [ncdf_pkg::G_W-1:0]     gauss_reg;

    // The estimate is never above the true quotient and at most one below.
    assign nprod_c = t[ncdf_pkg::T_W-1:ncdf_pkg::T_HI_LSB] * ncdf_pkg::N_RECIP;
    assign nl_c    = 38'(n1_reg) * 38'(ncdf_pkg::LN2_Q32);
    assign r_c     = {1'b0, t1_reg} - nl_c;
    assign ge_c    = r2_reg >= {1'b0, ncdf_pkg::LN2_Q32};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg   <= t;
            n1_reg   <= nprod_c[29:ncdf_pkg::NEST_SHIFT];
            far1_reg <= far;
            r2_reg   <= r_c[32:0];
            n2_reg   <= n1_reg;
            far2_reg <= far1_reg;
            q3_reg   <= ge_c ? 32'(r2_reg - {1'b0, ncdf_pkg::LN2_Q32}) : r2_reg[31:0];
            n3_reg   <= n2_reg + ncdf_pkg::N_W'(ge_c);
            far3_reg <= far2_reg;
        end
    end

    assign ser_q[0]   = q3_reg;
    assign ser_e[0]   = ncdf_pkg::ONE_Q32;
    assign ser_n[0]   = n3_reg;
    assign ser_far[0] = far3_reg;

    genvar k;
    generate
        for (k = 0; k < NT; k++) begin : g_term
            logic [64:0]              qe_c;
            logic [64:0]              pm_c;
            logic [31:0]              quot_c;
            logic [31:0]              p_reg;
            logic [31:0]              qa_reg;
            logic [ncdf_pkg::N_W-1:0] na_reg;
            logic                     fa_reg;
            logic [ncdf_pkg::E_W-1:0] e_reg;
            logic [31:0]              qb_reg;
            logic [ncdf_pkg::N_W-1:0] nb_reg;
            logic                     fb_reg;

            assign qe_c   = 65'(ser_q[k]) * 65'(ser_e[k]);
            assign pm_c   = 65'(p_reg) * 65'(ncdf_pkg::SER_MUL[k]);
            assign quot_c = 32'(pm_c >> ncdf_pkg::SER_SHIFT[k]);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    // q*e/2^32 never exceeds q, so 32 bits hold it.
                    p_reg  <= qe_c[63:32];
                    qa_reg <= ser_q[k];
                    na_reg <= ser_n[k];
                    fa_reg <= ser_far[k];
                    e_reg  <= ncdf_pkg::ONE_Q32 - {1'b0, quot_c};
                    qb_reg <= qa_reg;
                    nb_reg <= na_reg;
                    fb_reg <= fa_reg;
                end
            end

            assign ser_q[k+1]   = qb_reg;
            assign ser_e[k+1]   = e_reg;
            assign ser_n[k+1]   = nb_reg;
            assign ser_far[k+1] = fb_reg;
        end
    endgenerate

    assign g1prod_c = 65'(ser_e[NT]) * 65'(ncdf_pkg::INV_ROOT_2PI_Q32);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_reg    <= g1prod_c[62:32];
            nd_reg    <= ser_n[NT];
            fard_reg  <= ser_far[NT];
            gauss_reg <= fard_reg ? '0 : (g1_reg >> nd_reg);
        end
    end

    assign gauss = gauss_reg;

endmodule

// ===== rtl/ncdf_recip.sv =====
// ============================================================================
// ncdf_recip: pipelined reciprocal
// Restoring division of 2^64-1 by the denominator, one quotient bit a stage.
// ============================================================================
module ncdf_recip (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [ncdf_pkg::DEN_W-1:0]  den,
    output logic [31:0]                 recip
);

    localparam int NS = ncdf_pkg::RECIP_LAT;

    logic [ncdf_pkg::REM_W-1:0]  rem_s [NS+1];
    logic [ncdf_pkg::DEN_W-1:0]  den_s [NS+1];
    logic [31:0]                 quo_s [NS+1];

    // The upper half of the dividend is below any denominator, so the
    // quotient fits in 32 bits.
    assign rem_s[0] = ncdf_pkg::REM_W'(32'hFFFF_FFFF);
    assign den_s[0] = den;
    assign quo_s[0] = '0;

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_bit
            logic [ncdf_pkg::REM_W:0]    trial_c;
            logic [ncdf_pkg::REM_W:0]    diff_c;
            logic                        ge_c;
            logic [ncdf_pkg::REM_W-1:0]  rem_reg;
            logic [ncdf_pkg::DEN_W-1:0]  den_reg;
            logic [31:0]                 quo_reg;

            // Every dividend bit below the top half is one.
            assign trial_c = {rem_s[k], 1'b1};
            assign diff_c  = trial_c - {1'b0, den_s[k]};
            assign ge_c    = trial_c >= {1'b0, den_s[k]};

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg <= ge_c ? diff_c[ncdf_pkg::REM_W-1:0]
                                    : trial_c[ncdf_pkg::REM_W-1:0];
                    den_reg <= den_s[k];
                    quo_reg <= {quo_s[k][30:0], ge_c};
                end
            end

            assign rem_s[k+1] = rem_reg;
            assign den_s[k+1] = den_reg;
            assign quo_s[k+1] = quo_reg;
        end
    endgenerate

    assign recip = quo_s[NS];

endmodule

// ===== rtl/ncdf_horner.sv =====
// ============================================================================
// ncdf_horner: fifth-order polynomial in the reciprocal
// Each step is a magnitude multiply truncated toward zero, then a
// coefficient add; the last step has no add and its value is clamped at zero.
// ============================================================================
module ncdf_horner (
    input  logic         clk,
    input  logic         adv,
    input  logic [31:0]  recip,
    output logic [31:0]  poly
);

    localparam int NS = ncdf_pkg::HORN_STEPS;

    logic signed [ncdf_pkg::H_W-1:0]  h_s [NS];
    logic [31:0]                      r_s [NS];
    logic [31:0]                      poly_reg;

    assign h_s[0] = ncdf_pkg::HORN_INIT;
    assign r_s[0] = recip;

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_step
            logic [31:0]  hmag_c;
            logic [63:0]  prod_c;
            logic [31:0]  prod_reg;
            logic         sgn_reg;
            logic [31:0]  ra_reg;

            // Magnitude stays below 2^32: each sum is two values below 2^31.
            assign hmag_c = h_s[k][ncdf_pkg::H_W-1] ? 32'(-h_s[k]) : 32'(h_s[k]);
            assign prod_c = 64'(hmag_c) * 64'(r_s[k]);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod_reg <= prod_c[63:32];
                    sgn_reg  <= h_s[k][ncdf_pkg::H_W-1];
                    ra_reg   <= r_s[k];
                end
            end

            if (k < NS - 1) begin : g_add
                logic signed [ncdf_pkg::H_W-1:0]  sp_c;
                logic signed [ncdf_pkg::H_W-1:0]  h_reg;
                logic [31:0]                      rb_reg;

                assign sp_c = sgn_reg ? -$signed({2'b00, prod_reg})
                                      :  $signed({2'b00, prod_reg});

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        h_reg  <= sp_c + ncdf_pkg::HORN_ADD[k];
                        rb_reg <= ra_reg;
                    end
                end

                assign h_s[k+1] = h_reg;
                assign r_s[k+1] = rb_reg;
            end else begin : g_clamp
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        poly_reg <= sgn_reg ? '0 : prod_reg;
                    end
                end
            end
        end
    endgenerate

    assign poly = poly_reg;

endmodule

// ===== rtl/normal_cdf_polynomial.sv =====
// ============================================================================
// normal_cdf_polynomial: standard normal CDF and density, one per clock while not stalled
// Polynomial approximation 26.2.17: phi(|x|) * P(1/(1+gamma*|x|)), folded
// to the upper or lower tail by the sign of x, saturated to [0, 1.0].
// ============================================================================
//
//   Channel | Handshake              | Payload                  | Format
//   --------+------------------------+--------------------------+-----------------
//   input   | in_valid / in_stall    | x_in                     | signed Q4.27
//   output  | out_valid / out_stall  | cdf_out, density_out     | unsigned Q1.31
//
// One item enters per clock while in_stall is low. The pipeline depth is set
// by the 32-stage one-bit-per-stage reciprocal divider followed by the
// 10-stage Horner section.
// Reset clears the stage valid bits, the output valid bit and the skid slot.
// A stalled output parks one more result in the skid slot; in_stall follows
// that slot, so the whole pipeline freezes together and nothing is lost.
//
module normal_cdf_polynomial #(
    parameter int IN_WIDTH  = ncdf_pkg::IN_WIDTH_DEF,
    parameter int OUT_WIDTH = ncdf_pkg::OUT_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [IN_WIDTH-1:0]   x_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_WIDTH-1:0]  cdf_out,
    output logic [OUT_WIDTH-1:0]  density_out
);

    localparam int PD = ncdf_pkg::PIPE_DEPTH;
    localparam int ND = ncdf_pkg::NEG_DLY;
    localparam int GD = ncdf_pkg::GAUSS_DLY;

    // The whole pipeline moves as one while the skid slot is empty.
    logic adv;
    logic push;

    logic [PD-1:0]                    vld_reg;

    logic [ncdf_pkg::T_W-1:0]         t;
    logic [ncdf_pkg::DEN_W-1:0]       den;
    ncdf_pkg::front_flags_t           flags;
    logic [ncdf_pkg::G_W-1:0]         gauss;
    logic [31:0]                      recip;
    logic [31:0]                      poly;

    logic [ND-1:0]                    neg_dly_reg;
    logic [ncdf_pkg::G_W-1:0]         gauss_dly_reg [GD];

    logic [62:0]                      tail_prod_c;
    logic [31:0]                      tail_reg;
    logic                             neg_t_reg;
    logic [ncdf_pkg::G_W-1:0]         gauss_t_reg;

    logic [31:0]                      tail_sat_c;
    logic [31:0]                      cdf_c;
    logic [31:0]                      dens_c;
    logic [OUT_WIDTH-1:0]             cdf_conv_c;
    logic [OUT_WIDTH-1:0]             dens_conv_c;
    logic [OUT_WIDTH-1:0]             cdf_fin_reg;
    logic [OUT_WIDTH-1:0]             dens_fin_reg;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             skid_valid_reg;
    logic                             skid_valid_next;
    logic                             out_free;
    logic [OUT_WIDTH-1:0]             out_cdf_reg;
    logic [OUT_WIDTH-1:0]             out_dens_reg;
    logic [OUT_WIDTH-1:0]             skid_cdf_reg;
    logic [OUT_WIDTH-1:0]             skid_dens_reg;

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign push     = adv && vld_reg[PD-1];

    // Valid bits for every stage, shifted along with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PD-2:0], in_valid};
        end
    end

    ncdf_front #(
        .IN_WIDTH (IN_WIDTH)
    ) u_front (
        .clk   (clk),
        .adv   (adv),
        .x_in  (x_in),
        .t     (t),
        .den   (den),
        .flags (flags)
    );

    ncdf_exp u_exp (
        .clk   (clk),
        .adv   (adv),
        .t     (t),
        .far   (flags.far),
        .gauss (gauss)
    );

    ncdf_recip u_recip (
        .clk   (clk),
        .adv   (adv),
        .den   (den),
        .recip (recip)
    );

    ncdf_horner u_horner (
        .clk   (clk),
        .adv   (adv),
        .recip (recip),
        .poly  (poly)
    );

    // The density finishes before the polynomial does, and the sign is
    // needed only at the very end; both are delayed to line up.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_dly_reg      <= {neg_dly_reg[ND-2:0], flags.neg};
            gauss_dly_reg[0] <= gauss;
            for (int i = 1; i < GD; i++)
            begin
                gauss_dly_reg[i] <= gauss_dly_reg[i-1];
            end
        end
    end

    assign tail_prod_c = 63'(gauss_dly_reg[GD-1]) * 63'(poly);

    // Saturate the tail at 1.0 and fold it by the sign. Zero counts as
    // non-negative, so its probability is one minus the tail.
    assign tail_sat_c = (tail_reg > ncdf_pkg::ONE_Q31) ? ncdf_pkg::ONE_Q31 : tail_reg;
    assign cdf_c      = neg_t_reg ? tail_sat_c : (ncdf_pkg::ONE_Q31 - tail_sat_c);
    assign dens_c     = 32'(gauss_t_reg >> 1);

    generate
        if (OUT_WIDTH >= 32) begin : g_out_up
            assign cdf_conv_c  = OUT_WIDTH'(cdf_c) << (OUT_WIDTH - 32);
            assign dens_conv_c = OUT_WIDTH'(dens_c) << (OUT_WIDTH - 32);
        end else begin : g_out_down
            assign cdf_conv_c  = OUT_WIDTH'(cdf_c >> (32 - OUT_WIDTH));
            assign dens_conv_c = OUT_WIDTH'(dens_c >> (32 - OUT_WIDTH));
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tail_reg     <= tail_prod_c[62:31];
            neg_t_reg    <= neg_dly_reg[ND-1];
            gauss_t_reg  <= gauss_dly_reg[GD-1];
            cdf_fin_reg  <= cdf_conv_c;
            dens_fin_reg <= dens_conv_c;
        end
    end

    // Output register plus one skid slot. The slot fills only when a
    // result arrives while the output register is held by a stall.
    always_comb
    begin
        out_free        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_cdf_reg  <= skid_cdf_reg;
                out_dens_reg <= skid_dens_reg;
            end
            else if (push)
            begin
                out_cdf_reg  <= cdf_fin_reg;
                out_dens_reg <= dens_fin_reg;
            end
        end
        else if (push)
        begin
            skid_cdf_reg  <= cdf_fin_reg;
            skid_dens_reg <= dens_fin_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cdf_out     = out_cdf_reg;
    assign density_out = out_dens_reg;

endmodule

// ===== rtl/ncdf_checker.sv =====
// ============================================================================
// ncdf_checker: port-level checks for the normal CDF block
// Watches the handshakes and the result range; attached by bind.
// ============================================================================
module ncdf_checker #(
    parameter int OUT_WIDTH = ncdf_pkg::OUT_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [OUT_WIDTH-1:0]  cdf_out,
    input logic [OUT_WIDTH-1:0]  density_out
);

    localparam logic [OUT_WIDTH-1:0] ONE_OUT = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    // A held result keeps its value until it is transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cdf_out) && $stable(density_out))
        else $error("output changed while stalled");

    // Both results lie between 0 and 1.0.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cdf_out <= ONE_OUT) && (density_out <= ONE_OUT))
        else $error("result above 1.0");

    // The input side stalls only while a result sits in the output register.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty output");

    // The input stall starts only after the output was held by a stall.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall without an output stall");

endmodule

bind normal_cdf_polynomial ncdf_checker #(
    .OUT_WIDTH (OUT_WIDTH)
) u_ncdf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cdf_out     (cdf_out),
    .density_out (density_out)
);

// ===== dv/tb.sv =====
// ============================================================================
// tb: stream test of the normal CDF and density pipeline
// A queue of arguments feeds a bursty driver; a stalling monitor compares
// each result transfer against a fixed-point prediction of both outputs.
// ============================================================================
module tb;

    localparam int PIPE_LAT  = 48;
    localparam int IDLE_MAX  = 4000;
    localparam int N_RANDOM  = 1150;

    localparam logic [63:0] ONE_Q32  = 64'h1_0000_0000;
    localparam logic [63:0] ONE_Q31  = 64'h8000_0000;
    localparam logic [63:0] FAR_T    = 64'd32 << 32;
    localparam logic [63:0] INV_R2PI = 64'd1713444047;
    localparam logic [63:0] LN2_FIX  = 64'd2977044472;
    localparam logic [63:0] GAMMA_FX = ((64'd231641900 << 32) + 64'd500000000) / 64'd1000000000;
    localparam longint C1 = ((64'd319381530 << 30) + 64'd500000000) / 64'd1000000000;
    localparam longint C2 = ((64'd356563782 << 30) + 64'd500000000) / 64'd1000000000;
    localparam longint C3 = ((64'd1781477937 << 30) + 64'd500000000) / 64'd1000000000;
    localparam longint C4 = ((64'd1821255978 << 30) + 64'd500000000) / 64'd1000000000;
    localparam longint C5 = ((64'd1330274429 << 30) + 64'd500000000) / 64'd1000000000;

    typedef struct packed {
        logic [31:0] cdf;
        logic [31:0] density;
    } prob_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] x_in;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] cdf_out;
    logic [31:0] density_out;

    logic [31:0] arg_queue[$];
    prob_t       prob_queue[$];
    bit          stim_done;
    int          mismatches;
    int          burst_left;
    int          gap_left;
    int          idle_cycles;

    normal_cdf_polynomial u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .x_in        (x_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cdf_out     (cdf_out),
        .density_out (density_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Signed Horner term times the reciprocal, truncated toward zero.
    function automatic longint horner_mul(longint h, logic [63:0] r);
        logic [63:0] mag;
        mag = (h < 0) ? 64'(-h) : 64'(h);
        mag = ((mag & 64'hFFFF_FFFF) * r) >> 32;
        return (h < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Expected probability and density for one argument.
    function automatic prob_t normal_cdf_of(logic [31:0] x);
        logic [63:0] m;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] q;
        logic [63:0] e;
        logic [63:0] gauss;
        logic [63:0] den;
        logic [63:0] recip;
        logic [63:0] tail;
        longint      h;
        prob_t       res;
        m = x[31] ? 64'(32'(-x)) : 64'(x);
        if (x == 32'h8000_0000)
            m = 64'h8000_0000;
        t = (m * m) >> 23;
        gauss = 0;
        if (t < FAR_T)
        begin
            n = t / LN2_FIX;
            q = t - n * LN2_FIX;
            e = ONE_Q32;
            for (int j = 13; j >= 1; j--)
                e = ONE_Q32 - ((q * e) >> 32) / j;
            gauss = ((e * INV_R2PI) >> 32) >> n[5:0];
        end
        den = ONE_Q32 + ((m * GAMMA_FX) >> 27);
        recip = 64'hFFFF_FFFF_FFFF_FFFF / den;
        h = C5;
        h = horner_mul(h, recip) - C4;
        h = horner_mul(h, recip) + C3;
        h = horner_mul(h, recip) - C2;
        h = horner_mul(h, recip) + C1;
        h = horner_mul(h, recip);
        if (h < 0)
            h = 0;
        tail = (gauss * 64'(h)) >> 31;
        if (tail > ONE_Q31)
            tail = ONE_Q31;
        res.cdf = 32'(x[31] ? tail : ONE_Q31 - tail);
        res.density = 32'(gauss >> 1);
        return res;
    endfunction

    // Stimulus: directed corners first, then random arguments. Most random
    // values sit in the useful range of |x| below about 8; some cover all codes.
    initial
    begin
        logic [31:0] v;
        arg_queue.push_back(32'h0000_0000);
        arg_queue.push_back(32'h0000_0001);
        arg_queue.push_back(32'hFFFF_FFFF);
        arg_queue.push_back(32'h7FFF_FFFF);
        arg_queue.push_back(32'h8000_0000);
        arg_queue.push_back(32'h8000_0001);
        arg_queue.push_back(32'h0800_0000);
        arg_queue.push_back(32'hF800_0000);
        arg_queue.push_back(32'h1000_0000);
        arg_queue.push_back(32'hF000_0000);
        // Around the far-tail edge, x = 8.0 where x*x/2 reaches 32.
        arg_queue.push_back(32'h4000_0000);
        arg_queue.push_back(32'h3FFF_FFFF);
        arg_queue.push_back(32'hC000_0000);
        arg_queue.push_back(32'hC000_0001);
        arg_queue.push_back(32'h5555_5555);
        arg_queue.push_back(32'hAAAA_AAAA);
        arg_queue.push_back(32'h0400_0000);
        arg_queue.push_back(32'hFC00_0000);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    v = $urandom;
                2:       v = 32'($signed(32'($urandom_range(0, 255))) - 128);
                default: v = 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
            endcase
            arg_queue.push_back(v);
        end
        stim_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: bursts of random length separated by random gaps. The payload
    // only moves on after a transfer, so a stalled item holds steady.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            x_in       <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0 || arg_queue.size() == 0)
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                in_valid <= 1'b1;
                x_in     <= arg_queue[0];
                prob_queue.push_back(normal_cdf_of(arg_queue.pop_front()));
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 60);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver stall pattern: each cycle picks free flow, light or heavy stalling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            case (($urandom_range(0, 2047) + 0) % 3)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 7) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // Monitor: one result per transfer, compared with the oldest prediction.
    always @(posedge clk)
    begin
        prob_t exp_r;
        if (rst_n)
        begin
            idle_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall))
                ? 0 : idle_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (prob_queue.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result cdf=%h density=%h", cdf_out, density_out);
                end
                else
                begin
                    exp_r = prob_queue.pop_front();
                    if (exp_r.cdf !== cdf_out || exp_r.density !== density_out)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch cdf exp=%h got=%h density exp=%h got=%h",
                                     exp_r.cdf, cdf_out, exp_r.density, density_out);
                    end
                end
            end
        end
    end

    // End of run: all arguments sent and every prediction consumed, then a
    // drain to catch stray results. Watchdog on idling.
    initial
    begin
        mismatches  = 0;
        idle_cycles = 0;
        @(posedge rst_n);
        while (!(stim_done && arg_queue.size() == 0 && !in_valid && prob_queue.size() == 0)
               && idle_cycles < IDLE_MAX)
            @(posedge clk);
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            repeat (PIPE_LAT * 3) @(posedge clk);
            if (mismatches == 0 && prob_queue.size() == 0)
                $display("== PASS ==");
            else
                $display("== FAIL ==");
            $finish;
        end
    end

endmodule

// ===== normal_cdf_polynomial.f =====
rtl/ncdf_pkg.sv
rtl/ncdf_front.sv
rtl/ncdf_exp.sv
rtl/ncdf_recip.sv
rtl/ncdf_horner.sv
rtl/normal_cdf_polynomial.sv
rtl/ncdf_checker.sv
dv/tb.sv
